/* design/pttt_pkg.sv */
package pttt_pkg;

    // Sizing
    localparam int POSITION_BITS = 16;
    localparam int DEPTH_BITS    = 13;
    localparam int POS_EXT_W     = POSITION_BITS + 1;
    localparam int CORDIC_W      = DEPTH_BITS + 19;
    localparam int ACC_W         = 19;
    localparam int ANG_W         = 15;
    localparam int GAIN_W        = 6;
    localparam int PROD_W        = ANG_W + GAIN_W;
    localparam int FRAC_BITS     = 14;
    localparam int MV_W          = PROD_W - FRAC_BITS;
    localparam int PC_W          = 4;

    // Geometry and gains
    localparam logic [9:0]        CENTER_X   = 10'd320;
    localparam logic [8:0]        CENTER_Y   = 9'd240;
    localparam logic [GAIN_W-1:0] PAN_GAIN   = GAIN_W'(40);
    localparam logic [GAIN_W-1:0] TILT_GAIN  = GAIN_W'(20);
    localparam logic [ANG_W-1:0]  DEAD_BAND  = ANG_W'(81);
    localparam logic [7:0]        CMD_POSITION = 8'd80;
    localparam logic [3:0]        ITER_LAST  = 4'd15;

    // Register map
    localparam logic [7:0] CFG_MATCH_ANY = 8'd0;
    localparam logic [7:0] CFG_USER      = 8'd1;
    localparam logic [7:0] CFG_PAN_ID    = 8'd2;
    localparam logic [7:0] CFG_TILT_ID   = 8'd3;

    // Channel payloads
    typedef struct packed {
        logic [7:0]  point_user;
        logic [9:0]  image_x;
        logic [8:0]  image_y;
        logic [12:0] range_z;
        logic        last_point;
    } t_pt_item;

    typedef struct packed {
        logic [7:0]         motor_select;
        logic [7:0]         command_code;
        logic signed [15:0] target_position;
    } t_cmd_item;

    // Microcode
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_LOAD_PAN,
        OP_LOAD_TILT,
        OP_ITER,
        OP_SAVE_PAN,
        OP_SAVE_TILT,
        OP_MOVE,
        OP_EMIT
    } t_op;

    // C_NEXT: step on; C_START: hold until a target point is taken;
    // C_LOOP: jump while iterations remain; C_OUT: hold while the output
    // register is full and not taken, then jump; C_JUMP: jump unconditionally
    typedef enum logic [2:0] {
        C_NEXT,
        C_START,
        C_LOOP,
        C_OUT,
        C_JUMP
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uop;

    localparam t_pc PC_WAIT      = 4'd0;
    localparam t_pc PC_LOAD_PAN  = 4'd1;
    localparam t_pc PC_ITER_PAN  = 4'd2;
    localparam t_pc PC_SAVE_PAN  = 4'd3;
    localparam t_pc PC_LOAD_TILT = 4'd4;
    localparam t_pc PC_ITER_TILT = 4'd5;
    localparam t_pc PC_SAVE_TILT = 4'd6;
    localparam t_pc PC_MOVE      = 4'd7;
    localparam t_pc PC_EMIT      = 4'd8;

    function automatic t_uop ucode_rom(input t_pc pc);
        t_uop u;
        case (pc)
            PC_WAIT:      u = '{OP_WAIT,      C_START, PC_WAIT};
            PC_LOAD_PAN:  u = '{OP_LOAD_PAN,  C_NEXT,  PC_WAIT};
            PC_ITER_PAN:  u = '{OP_ITER,      C_LOOP,  PC_ITER_PAN};
            PC_SAVE_PAN:  u = '{OP_SAVE_PAN,  C_NEXT,  PC_WAIT};
            PC_LOAD_TILT: u = '{OP_LOAD_TILT, C_NEXT,  PC_WAIT};
            PC_ITER_TILT: u = '{OP_ITER,      C_LOOP,  PC_ITER_TILT};
            PC_SAVE_TILT: u = '{OP_SAVE_TILT, C_NEXT,  PC_WAIT};
            PC_MOVE:      u = '{OP_MOVE,      C_NEXT,  PC_WAIT};
            PC_EMIT:      u = '{OP_EMIT,      C_OUT,   PC_WAIT};
            default:      u = '{OP_WAIT,      C_JUMP,  PC_WAIT};
        endcase
        return u;
    endfunction

    // atan(2^-i) in Q0.16, rounded to nearest
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] a;
        case (i)
            4'd0:    a = 16'd51472;
            4'd1:    a = 16'd30386;
            4'd2:    a = 16'd16055;
            4'd3:    a = 16'd8150;
            4'd4:    a = 16'd4091;
            4'd5:    a = 16'd2047;
            4'd6:    a = 16'd1024;
            4'd7:    a = 16'd512;
            4'd8:    a = 16'd256;
            4'd9:    a = 16'd128;
            4'd10:   a = 16'd64;
            4'd11:   a = 16'd32;
            4'd12:   a = 16'd16;
            4'd13:   a = 16'd8;
            4'd14:   a = 16'd4;
            default: a = 16'd2;
        endcase
        return a;
    endfunction

    // Arithmetic right shift that truncates toward zero
    function automatic logic signed [CORDIC_W-1:0] shr_tz(
        input logic signed [CORDIC_W-1:0] v,
        input logic [3:0]                 s
    );
        logic [CORDIC_W-1:0] m;
        m = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
        m = m >> s;
        return v[CORDIC_W-1] ? signed'(CORDIC_W'(-m)) : signed'(m);
    endfunction

endpackage

/* design/pttt_if.sv */
interface pttt_in_if import pttt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_pt_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pttt_out_if import pttt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/pan_tilt_target_tracker.sv */
// Pan/tilt tracker: takes one tracked point per transfer and, for the first
// point of each frame that passes the user filter, works out pan and tilt
// angles with a single shared CORDIC stage run 16 times per axis, then issues
// at most one position command ('P', pan first, tilt only when pan did not
// move). The command is loaded into the output register after these steps:
// for each axis in turn a load, 16 CORDIC iterations and a save, then one
// step for both moves and one for saturation and update. A target holds the
// sequencer from its accept step to that last step; points that are not a
// target are accepted and dropped without leaving the wait step. The next
// point is accepted while a command still waits at the output; the final step
// of a target waits only while the previous command has not been taken.
// Configuration is a write-only port, indexed 0..3 as match_any_user,
// tracked_user, pan_motor_id, tilt_motor_id.
module pan_tilt_target_tracker import pttt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    pttt_in_if.sink     i_pts,
    pttt_out_if.source  o_cmd
);

    // Configuration
    logic       r_match_any;
    logic [7:0] r_user;
    logic [7:0] r_pan_id;
    logic [7:0] r_tilt_id;

    // Sequencer
    t_pc  r_pc;
    t_pc  n_pc;
    t_uop uop;

    // Frame and target point
    logic                  r_frame_matched;
    logic [9:0]            r_offx;
    logic [8:0]            r_offy;
    logic [DEPTH_BITS-1:0] r_z;
    logic                  r_pan_neg;
    logic                  r_tilt_neg;

    // CORDIC datapath
    logic signed [CORDIC_W-1:0] r_cx;
    logic signed [CORDIC_W-1:0] r_cy;
    logic signed [ACC_W-1:0]    r_acc;
    logic [3:0]                 r_iter;
    logic [ANG_W-1:0]           r_ang_pan;
    logic [ANG_W-1:0]           r_ang_tilt;

    // Positions and moves
    logic signed [POSITION_BITS-1:0] r_pan_pos;
    logic signed [POSITION_BITS-1:0] r_tilt_pos;
    logic signed [POS_EXT_W-1:0]     r_mv_pan;
    logic signed [POS_EXT_W-1:0]     r_mv_tilt;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_sel;
    logic [15:0] r_out_pos;

    logic pts_xfer;
    logic qualify;
    logic start;
    logic out_free;

    logic [9:0]  in_offx;
    logic [8:0]  in_offy;
    logic [15:0] in_z16;

    logic [9:0]                 load_off;
    logic signed [CORDIC_W-1:0] cdx;
    logic signed [CORDIC_W-1:0] cdy;
    logic signed [ACC_W-1:0]    cat;
    logic [ACC_W-1:0]           acc_rnd;
    logic [ANG_W-1:0]           ang_res;

    logic [PROD_W-1:0] prod_pan;
    logic [PROD_W-1:0] prod_tilt;
    logic [MV_W-1:0]   q_pan;
    logic [MV_W-1:0]   q_tilt;

    logic signed [POS_EXT_W-1:0]     sum_pan;
    logic signed [POS_EXT_W-1:0]     sum_tilt;
    logic signed [POSITION_BITS-1:0] sat_pan;
    logic signed [POSITION_BITS-1:0] sat_tilt;
    logic signed [31:0]              pan_w;
    logic signed [31:0]              tilt_w;

    // Handshake
    assign uop         = ucode_rom(r_pc);
    assign i_pts.ready = (uop.op == OP_WAIT);
    assign pts_xfer    = i_pts.valid && i_pts.ready;
    assign qualify     = !r_frame_matched &&
                         (r_match_any || (i_pts.data.point_user == r_user));
    assign start       = pts_xfer && qualify;
    assign out_free    = !r_out_valid || o_cmd.ready;

    assign o_cmd.valid                = r_out_valid;
    assign o_cmd.data.motor_select    = r_out_sel;
    assign o_cmd.data.command_code    = CMD_POSITION;
    assign o_cmd.data.target_position = signed'(r_out_pos);

    // Offset magnitudes of the incoming point
    assign in_offx = (i_pts.data.image_x >= CENTER_X) ? i_pts.data.image_x - CENTER_X
                                                       : CENTER_X - i_pts.data.image_x;
    assign in_offy = (i_pts.data.image_y >= CENTER_Y) ? i_pts.data.image_y - CENTER_Y
                                                       : CENTER_Y - i_pts.data.image_y;
    assign in_z16  = 16'(i_pts.data.range_z);

    // CORDIC step and angle finish
    assign load_off = (uop.op == OP_LOAD_PAN) ? r_offx : 10'(r_offy);
    assign cdx      = shr_tz(r_cy, r_iter);
    assign cdy      = shr_tz(r_cx, r_iter);
    assign cat      = signed'(ACC_W'(atan_q16(r_iter)));
    assign acc_rnd  = ACC_W'(r_acc) + ACC_W'(2);

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            ang_res = '0;
        end else begin
            ang_res = acc_rnd[ANG_W+1:2];
        end
    end

    // Move magnitudes
    assign prod_pan  = PROD_W'(r_ang_pan) * PROD_W'(PAN_GAIN);
    assign prod_tilt = PROD_W'(r_ang_tilt) * PROD_W'(TILT_GAIN);
    assign q_pan     = prod_pan[PROD_W-1:FRAC_BITS];
    assign q_tilt    = prod_tilt[PROD_W-1:FRAC_BITS];

    // New positions with saturation
    assign sum_pan  = POS_EXT_W'(r_pan_pos) + r_mv_pan;
    assign sum_tilt = POS_EXT_W'(r_tilt_pos) + r_mv_tilt;

    always_comb begin
        if (sum_pan[POS_EXT_W-1] != sum_pan[POSITION_BITS-1]) begin
            sat_pan = sum_pan[POS_EXT_W-1] ? {1'b1, {(POSITION_BITS-1){1'b0}}}
                                           : {1'b0, {(POSITION_BITS-1){1'b1}}};
        end else begin
            sat_pan = sum_pan[POSITION_BITS-1:0];
        end
        if (sum_tilt[POS_EXT_W-1] != sum_tilt[POSITION_BITS-1]) begin
            sat_tilt = sum_tilt[POS_EXT_W-1] ? {1'b1, {(POSITION_BITS-1){1'b0}}}
                                             : {1'b0, {(POSITION_BITS-1){1'b1}}};
        end else begin
            sat_tilt = sum_tilt[POSITION_BITS-1:0];
        end
    end

    assign pan_w  = 32'(sat_pan);
    assign tilt_w = 32'(sat_tilt);

    // Next step of the microprogram
    always_comb begin
        n_pc = r_pc + t_pc'(1);
        case (uop.cond)
            C_NEXT:  n_pc = r_pc + t_pc'(1);
            C_START: n_pc = start ? r_pc + t_pc'(1) : r_pc;
            C_LOOP:  n_pc = (r_iter != ITER_LAST) ? uop.target : r_pc + t_pc'(1);
            C_OUT:   n_pc = out_free ? uop.target : r_pc;
            C_JUMP:  n_pc = uop.target;
            default: n_pc = PC_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_any <= 1'b1;
            r_user      <= 8'd0;
            r_pan_id    <= 8'd0;
            r_tilt_id   <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MATCH_ANY: r_match_any <= i_cfg_data[0];
                CFG_USER:      r_user      <= i_cfg_data;
                CFG_PAN_ID:    r_pan_id    <= i_cfg_data;
                CFG_TILT_ID:   r_tilt_id   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame state, positions and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_matched <= 1'b0;
            r_pan_pos       <= '0;
            r_tilt_pos      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (pts_xfer) begin
                // a target on the last point leaves the frame closed as well
                if (i_pts.data.last_point) begin
                    r_frame_matched <= 1'b0;
                end else if (qualify) begin
                    r_frame_matched <= 1'b1;
                end
            end

            if (o_cmd.ready) begin
                r_out_valid <= 1'b0;
            end

            if (uop.op == OP_EMIT && out_free) begin
                if (sat_pan != r_pan_pos) begin
                    r_pan_pos   <= sat_pan;
                    r_out_valid <= 1'b1;
                end else if (sat_tilt != r_tilt_pos) begin
                    r_tilt_pos  <= sat_tilt;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (uop.op)
            OP_WAIT: begin
                if (start) begin
                    r_offx     <= in_offx;
                    r_offy     <= in_offy;
                    r_z        <= in_z16[DEPTH_BITS-1:0];
                    r_pan_neg  <= (i_pts.data.image_x >= CENTER_X);
                    r_tilt_neg <= (i_pts.data.image_y >= CENTER_Y);
                end
            end
            OP_LOAD_PAN, OP_LOAD_TILT: begin
                r_cx   <= signed'(CORDIC_W'(r_z) << 16);
                r_cy   <= signed'(CORDIC_W'(load_off) << 16);
                r_acc  <= '0;
                r_iter <= '0;
            end
            OP_ITER: begin
                if (!r_cy[CORDIC_W-1]) begin
                    r_cx  <= r_cx + cdx;
                    r_cy  <= r_cy - cdy;
                    r_acc <= r_acc + cat;
                end else begin
                    r_cx  <= r_cx - cdx;
                    r_cy  <= r_cy + cdy;
                    r_acc <= r_acc - cat;
                end
                r_iter <= r_iter + 4'd1;
            end
            OP_SAVE_PAN: begin
                r_ang_pan <= (r_offx == '0) ? '0 : ang_res;
            end
            OP_SAVE_TILT: begin
                r_ang_tilt <= (r_offy == '0) ? '0 : ang_res;
            end
            OP_MOVE: begin
                // dead band: no move unless the angle exceeds it
                if (r_ang_pan > DEAD_BAND) begin
                    r_mv_pan <= r_pan_neg ? -POS_EXT_W'(q_pan) : POS_EXT_W'(q_pan);
                end else begin
                    r_mv_pan <= '0;
                end
                if (r_ang_tilt > DEAD_BAND) begin
                    r_mv_tilt <= r_tilt_neg ? -POS_EXT_W'(q_tilt) : POS_EXT_W'(q_tilt);
                end else begin
                    r_mv_tilt <= '0;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    if (sat_pan != r_pan_pos) begin
                        r_out_sel <= r_pan_id;
                        r_out_pos <= pan_w[15:0];
                    end else begin
                        r_out_sel <= r_tilt_id;
                        r_out_pos <= tilt_w[15:0];
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_pc == PC_LOAD_PAN))
        else $error("target point did not start the pan load step");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pts_xfer && i_pts.data.last_point) |=> !r_frame_matched)
        else $error("frame still marked matched after its last point");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_pc) == PC_EMIT))
        else $error("command loaded outside the emit step");

    a_loop_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_ITER_TILT && r_iter == ITER_LAST) |=> (r_pc == PC_SAVE_TILT))
        else $error("tilt iteration loop did not exit after the last step");
`endif

endmodule
